[rtl/isc_pkg.sv]
package isc_pkg;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 152;

    localparam logic [31:0] MASK_CLASS_A = 32'hff00_0000;
    localparam logic [31:0] MASK_CLASS_B = 32'hffff_0000;
    localparam logic [31:0] MASK_CLASS_C = 32'hffff_ff00;
    localparam logic [31:0] MASK_ALL     = 32'hffff_ffff;

    localparam logic [5:0] PREFIX_PTP = 6'd31;
    localparam logic [5:0] PREFIX_MAX = 6'd32;

    typedef enum logic [2:0] {
        CLS_A        = 3'd0,
        CLS_B        = 3'd1,
        CLS_C        = 3'd2,
        CLS_D        = 3'd3,
        CLS_E        = 3'd4,
        CLS_BCAST    = 3'd5,
        CLS_NONEXIST = 3'd6
    } addr_class_t;

    typedef enum logic [4:0] {
        RNG_NONE       = 5'd0,
        RNG_CURRENT    = 5'd1,
        RNG_PRIVATE10  = 5'd2,
        RNG_LOOPBACK   = 5'd3,
        RNG_LINKLOCAL  = 5'd4,
        RNG_PRIVATE172 = 5'd5,
        RNG_PRIVATE192 = 5'd6,
        RNG_RELAY      = 5'd7,
        RNG_IANA       = 5'd8,
        RNG_TESTNET1   = 5'd9,
        RNG_BENCH      = 5'd10,
        RNG_TESTNET2   = 5'd11,
        RNG_TESTNET3   = 5'd12,
        RNG_MULTICAST  = 5'd13,
        RNG_FUTURE     = 5'd14,
        RNG_BCAST      = 5'd15,
        RNG_NONEXIST   = 5'd16
    } range_code_t;

    // Classification of the first three octets; need is the range's own
    // prefix length, zero for ranges that have none.
    typedef struct packed {
        addr_class_t cls;
        range_code_t code;
        logic [4:0]  need;
    } class_info_t;

endpackage

[rtl/isc_class_decode.sv]
module isc_class_decode
    import isc_pkg::*;
(
    input  logic [31:0] host_addr,
    output class_info_t info
);

    logic [7:0] o1;
    logic [7:0] o2;
    logic [7:0] o3;

    assign o1 = host_addr[31:24];
    assign o2 = host_addr[23:16];
    assign o3 = host_addr[15:8];

    always_comb
    begin
        info.cls  = CLS_NONEXIST;
        info.code = RNG_NONE;
        info.need = 5'd0;
        case (o1) inside
            [8'd0:8'd127]:
            begin
                info.cls = CLS_A;
                if (o1 == 8'd0)
                begin
                    info.code = RNG_CURRENT;
                    info.need = 5'd8;
                end
                if (o1 == 8'd10)
                begin
                    info.code = RNG_PRIVATE10;
                    info.need = 5'd8;
                end
                if (o1 == 8'd127)
                begin
                    info.code = RNG_LOOPBACK;
                    info.need = 5'd8;
                end
            end
            [8'd128:8'd191]:
            begin
                info.cls = CLS_B;
                if (o1 == 8'd169 && o2 == 8'd254)
                begin
                    info.code = RNG_LINKLOCAL;
                    info.need = 5'd16;
                end
                if (o1 == 8'd172 && o2[7:4] == 4'd1)
                begin
                    info.code = RNG_PRIVATE172;
                    info.need = 5'd12;
                end
            end
            [8'd192:8'd223]:
            begin
                info.cls = CLS_C;
                if (o1 == 8'd192 && o2 == 8'd168)
                begin
                    info.code = RNG_PRIVATE192;
                    info.need = 5'd16;
                end
                if (o1 == 8'd192 && o2 == 8'd88 && o3 == 8'd99)
                begin
                    info.code = RNG_RELAY;
                    info.need = 5'd24;
                end
                if (o1 == 8'd192 && o2 == 8'd0 && o3 == 8'd0)
                begin
                    info.code = RNG_IANA;
                    info.need = 5'd24;
                end
                if (o1 == 8'd192 && o2 == 8'd0 && o3 == 8'd2)
                begin
                    info.code = RNG_TESTNET1;
                    info.need = 5'd24;
                end
                // The benchmark block is matched on its first /24 only but
                // is judged against its real /15 length.
                if (o1 == 8'd198 && o2 == 8'd18 && o3 == 8'd0)
                begin
                    info.code = RNG_BENCH;
                    info.need = 5'd15;
                end
                if (o1 == 8'd198 && o2 == 8'd51 && o3 == 8'd100)
                begin
                    info.code = RNG_TESTNET2;
                    info.need = 5'd24;
                end
                if (o1 == 8'd203 && o2 == 8'd0 && o3 == 8'd113)
                begin
                    info.code = RNG_TESTNET3;
                    info.need = 5'd24;
                end
            end
            [8'd224:8'd239]:
            begin
                info.cls  = CLS_D;
                info.code = RNG_MULTICAST;
            end
            [8'd240:8'd247]:
            begin
                info.cls  = CLS_E;
                info.code = RNG_FUTURE;
            end
            8'd255:
            begin
                info.cls  = CLS_BCAST;
                info.code = RNG_BCAST;
            end
            default:
            begin
                info.cls  = CLS_NONEXIST;
                info.code = RNG_NONEXIST;
            end
        endcase
    end

endmodule

[rtl/ipv4_subnet_classifier.sv]
// IPv4 subnet classifier: each input transaction carries a host address and
// a netmask, and each output transaction carries the matching result. The
// block is a three-stage pipeline (mask check, byte popcounts and octet
// decode; prefix sum and address masking; range-length compare and final
// zeroing) and accepts one transaction every cycle while the output is not
// stalled. Every stage holds its own valid bit and moves only when the stage
// after it is empty or moving, so back-pressure on the output stops the
// pipeline without loss while empty stages keep taking input. A netmask
// with a one bit below a zero bit gives bad_mask set and all other result
// fields zero. There is no configuration and no state between transactions.
module ipv4_subnet_classifier
    import isc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // host_addr [31:0], net_mask [63:32]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // bad_mask [0], mask_len [6:1], network_addr [38:7],
    // broadcast_addr [70:39], classful_mask [102:71],
    // classful_network [134:103], addr_class [137:135], range_code [142:138],
    // in_part [143], ptp_link [144], zero fill [151:145]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [31:0] in_host;
    logic [31:0] in_mask;
    logic [31:0] in_inv;
    logic        in_bad;
    logic [3:0]  in_cnt [4];
    class_info_t in_info;

    logic adv1;
    logic adv2;
    logic adv3;

    // Stage 1 registers.
    logic        s1_valid_reg;
    logic [31:0] s1_host_reg;
    logic [31:0] s1_mask_reg;
    logic        s1_bad_reg;
    logic [3:0]  s1_cnt_reg [4];
    class_info_t s1_info_reg;

    // Stage 2 registers.
    logic        s2_valid_reg;
    logic        s2_bad_reg;
    logic [5:0]  s2_len_reg;
    logic [31:0] s2_net_reg;
    logic [31:0] s2_bcast_reg;
    logic [31:0] s2_cmask_reg;
    logic [31:0] s2_cnet_reg;
    class_info_t s2_info_reg;

    logic [5:0]  s2_len_next;
    logic [31:0] s2_cmask_next;

    // Stage 3 registers form the output.
    logic        s3_valid_reg;
    logic        s3_bad_reg;
    logic [5:0]  s3_len_reg;
    logic [31:0] s3_net_reg;
    logic [31:0] s3_bcast_reg;
    logic [31:0] s3_cmask_reg;
    logic [31:0] s3_cnet_reg;
    logic [2:0]  s3_cls_reg;
    logic [4:0]  s3_code_reg;
    logic        s3_in_part_reg;
    logic        s3_ptp_reg;

    logic        s3_in_part_next;
    logic        s3_ptp_next;

    assign adv3 = !s3_valid_reg || m_axis_tready;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;
    assign s_axis_tready = adv1;

    assign in_host = s_axis_tdata[31:0];
    assign in_mask = s_axis_tdata[63:32];
    assign in_inv  = ~in_mask;
    // The inverted mask must be a run of ones from bit 0 upward.
    assign in_bad  = (in_inv & (in_inv + 32'd1)) != 32'd0;

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            in_cnt[b] = 4'd0;
            for (int i = 0; i < 8; i++)
            begin
                in_cnt[b] = in_cnt[b] + {3'd0, in_mask[8*b+i]};
            end
        end
    end

    isc_class_decode u_decode
    (
        .host_addr (in_host),
        .info      (in_info)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && s_axis_tvalid)
        begin
            s1_host_reg <= in_host;
            s1_mask_reg <= in_mask;
            s1_bad_reg  <= in_bad;
            s1_cnt_reg  <= in_cnt;
            s1_info_reg <= in_info;
        end
    end

    assign s2_len_next = {2'd0, s1_cnt_reg[0]} + {2'd0, s1_cnt_reg[1]}
                       + {2'd0, s1_cnt_reg[2]} + {2'd0, s1_cnt_reg[3]};

    always_comb
    begin
        case (s1_info_reg.cls)
            CLS_A:   s2_cmask_next = MASK_CLASS_A;
            CLS_B:   s2_cmask_next = MASK_CLASS_B;
            CLS_C:   s2_cmask_next = MASK_CLASS_C;
            default: s2_cmask_next = s1_mask_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            s2_bad_reg   <= s1_bad_reg;
            s2_len_reg   <= s2_len_next;
            s2_net_reg   <= s1_host_reg & s1_mask_reg;
            s2_bcast_reg <= (s1_host_reg & s1_mask_reg) | (s1_mask_reg ^ MASK_ALL);
            s2_cmask_reg <= s2_cmask_next;
            s2_cnet_reg  <= s1_host_reg & s2_cmask_next;
            s2_info_reg  <= s1_info_reg;
        end
    end

    assign s3_in_part_next = (s2_info_reg.need != 5'd0)
                          && (s2_len_reg < {1'b0, s2_info_reg.need});
    assign s3_ptp_next     = (s2_len_reg == PREFIX_PTP)
                          && (s2_info_reg.code != RNG_NONE)
                          && (s2_info_reg.code != RNG_NONEXIST);

    always_ff @(posedge clk)
    begin
        if (adv3 && s2_valid_reg)
        begin
            s3_bad_reg <= s2_bad_reg;
            if (s2_bad_reg)
            begin
                s3_len_reg     <= 6'd0;
                s3_net_reg     <= 32'd0;
                s3_bcast_reg   <= 32'd0;
                s3_cmask_reg   <= 32'd0;
                s3_cnet_reg    <= 32'd0;
                s3_cls_reg     <= CLS_A;
                s3_code_reg    <= RNG_NONE;
                s3_in_part_reg <= 1'b0;
                s3_ptp_reg     <= 1'b0;
            end
            else
            begin
                s3_len_reg     <= s2_len_reg;
                s3_net_reg     <= s2_net_reg;
                s3_bcast_reg   <= s2_bcast_reg;
                s3_cmask_reg   <= s2_cmask_reg;
                s3_cnet_reg    <= s2_cnet_reg;
                s3_cls_reg     <= s2_info_reg.cls;
                s3_code_reg    <= s2_info_reg.code;
                s3_in_part_reg <= s3_in_part_next;
                s3_ptp_reg     <= s3_ptp_next;
            end
        end
    end

    assign m_axis_tvalid = s3_valid_reg;
    assign m_axis_tdata  = {7'd0, s3_ptp_reg, s3_in_part_reg, s3_code_reg, s3_cls_reg,
                            s3_cnet_reg, s3_cmask_reg, s3_bcast_reg, s3_net_reg,
                            s3_len_reg, s3_bad_reg};

endmodule

[rtl/isc_checker.sv]
module isc_checker
    import isc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A result held back by the sink must stay put until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

    // A bad mask clears every other field.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[OUT_DATA_W-1:1] == '0)
        else $error("bad mask result carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[6:1] <= PREFIX_MAX)
        else $error("prefix length above 32");

    // A point-to-point link is only reported for a /31.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[144] |-> m_axis_tdata[6:1] == PREFIX_PTP)
        else $error("point-to-point flag without a /31 prefix");

    // A partial range needs a range that has a length of its own.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[143]
            |-> m_axis_tdata[142:138] != RNG_NONE
             && m_axis_tdata[142:138] <= RNG_TESTNET3)
        else $error("in-part flag on a range without a length");

endmodule

bind ipv4_subnet_classifier isc_checker u_isc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import isc_pkg::*;

    typedef struct packed {
        logic          ptp_link;
        logic          in_part;
        range_code_t   range_code;
        addr_class_t   addr_class;
        logic [31:0]   classful_network;
        logic [31:0]   classful_mask;
        logic [31:0]   broadcast_addr;
        logic [31:0]   network_addr;
        logic [5:0]    mask_len;
        logic          bad_mask;
    } subnet_info_t;

    typedef struct packed {
        logic [31:0]   host;
        logic [31:0]   mask;
        logic          typed;
        subnet_info_t  want;
    } stim_row_t;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int HOLD_AFTER = 1000;
    localparam int PAUSE_AT = 600;
    localparam int RANDOM_ITEMS = 1875;
    localparam int DIRECTED_ROWS = 25;
    localparam int TAIL_CYCLES = 20;

    localparam subnet_info_t NULL_INFO = '{
        ptp_link: 1'b0, in_part: 1'b0, range_code: RNG_NONE, addr_class: CLS_A,
        classful_network: 32'h0, classful_mask: 32'h0, broadcast_addr: 32'h0,
        network_addr: 32'h0, mask_len: 6'd0, bad_mask: 1'b0};

    localparam subnet_info_t BAD_MASK_INFO = '{
        ptp_link: 1'b0, in_part: 1'b0, range_code: RNG_NONE, addr_class: CLS_A,
        classful_network: 32'h0, classful_mask: 32'h0, broadcast_addr: 32'h0,
        network_addr: 32'h0, mask_len: 6'd0, bad_mask: 1'b1};

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    subnet_info_t pending_info [$];
    int           error_count = 0;
    int           results_seen = 0;
    int           idle_cycles = 0;
    bit           calm = 1'b0;
    bit           hold_done = 1'b0;

    int near_len [15] = '{0, 1, 4, 7, 8, 11, 12, 14, 15, 16, 23, 24, 30, 31, 32};

    stim_row_t dir_rows [DIRECTED_ROWS] = '{
        // Shortest prefix on the all-zero address: current network, only part of it.
        '{32'h0000_0000, 32'h0000_0000, 1'b1, '{
            ptp_link: 1'b0, in_part: 1'b1, range_code: RNG_CURRENT, addr_class: CLS_A,
            classful_network: 32'h0, classful_mask: MASK_CLASS_A,
            broadcast_addr: MASK_ALL, network_addr: 32'h0, mask_len: 6'd0,
            bad_mask: 1'b0}},
        // Host route on the limited broadcast address.
        '{32'hffff_ffff, 32'hffff_ffff, 1'b1, '{
            ptp_link: 1'b0, in_part: 1'b0, range_code: RNG_BCAST, addr_class: CLS_BCAST,
            classful_network: MASK_ALL, classful_mask: MASK_ALL,
            broadcast_addr: MASK_ALL, network_addr: MASK_ALL, mask_len: PREFIX_MAX,
            bad_mask: 1'b0}},
        '{32'h1234_5678, 32'h0000_0001, 1'b1, BAD_MASK_INFO},
        '{32'hffff_ffff, 32'h7fff_ffff, 1'b1, BAD_MASK_INFO},
        '{32'h0a00_0001, 32'hfffe_ffff, 1'b1, BAD_MASK_INFO},
        '{32'h0000_0000, 32'h8000_0001, 1'b1, BAD_MASK_INFO},
        '{32'h0a01_0203, 32'hff00_0000, 1'b0, NULL_INFO},
        '{32'h0a01_0203, 32'hfe00_0000, 1'b0, NULL_INFO},
        '{32'h7f00_0001, 32'hffff_fffe, 1'b0, NULL_INFO},
        '{32'ha9fe_0101, 32'hffff_0000, 1'b0, NULL_INFO},
        '{32'ha9fe_0101, 32'hfffe_0000, 1'b0, NULL_INFO},
        '{32'hac10_0504, 32'hfff0_0000, 1'b0, NULL_INFO},
        '{32'hac1f_0001, 32'hffe0_0000, 1'b0, NULL_INFO},
        '{32'hac20_0001, 32'hfff0_0000, 1'b0, NULL_INFO},
        '{32'hc0a8_0101, 32'hffff_0000, 1'b0, NULL_INFO},
        '{32'hc058_6301, 32'hffff_ff00, 1'b0, NULL_INFO},
        '{32'hc000_0008, 32'hffff_fe00, 1'b0, NULL_INFO},
        '{32'hc000_0201, 32'hffff_fffe, 1'b0, NULL_INFO},
        '{32'hc612_0001, 32'hfffe_0000, 1'b0, NULL_INFO},
        '{32'hc612_0101, 32'hfffe_0000, 1'b0, NULL_INFO},
        '{32'hc633_6407, 32'hffff_ff00, 1'b0, NULL_INFO},
        '{32'hcb00_7109, 32'hffff_ffff, 1'b0, NULL_INFO},
        '{32'he000_0001, 32'hf000_0000, 1'b0, NULL_INFO},
        '{32'hf001_0203, 32'hffff_fffe, 1'b0, NULL_INFO},
        '{32'hfa00_0001, 32'hffff_fffe, 1'b0, NULL_INFO}
    };

    ipv4_subnet_classifier DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic subnet_info_t compute_subnet_info(logic [31:0] host,
                                                         logic [31:0] mask);
        subnet_info_t r;
        logic [31:0]  inv_mask;
        logic [7:0]   o1;
        logic [7:0]   o2;
        logic [7:0]   o3;
        logic [5:0]   need;
        r = NULL_INFO;
        inv_mask = ~mask;
        // A contiguous mask inverts to a run of ones in the low bits.
        if ((inv_mask & (inv_mask + 32'd1)) != 32'd0)
        begin
            r.bad_mask = 1'b1;
            return r;
        end
        o1 = host[31:24];
        o2 = host[23:16];
        o3 = host[15:8];
        need = 6'd0;
        r.mask_len = 6'($countones(mask));
        r.network_addr = host & mask;
        r.broadcast_addr = (host & mask) | inv_mask;
        r.classful_mask = mask;
        if (!o1[7])
        begin
            r.addr_class = CLS_A;
            r.classful_mask = MASK_CLASS_A;
            if (o1 == 8'd0)
            begin
                r.range_code = RNG_CURRENT;
                need = 6'd8;
            end
            if (o1 == 8'd10)
            begin
                r.range_code = RNG_PRIVATE10;
                need = 6'd8;
            end
            if (o1 == 8'd127)
            begin
                r.range_code = RNG_LOOPBACK;
                need = 6'd8;
            end
        end
        else if (o1[7:6] == 2'b10)
        begin
            r.addr_class = CLS_B;
            r.classful_mask = MASK_CLASS_B;
            if (o1 == 8'd169 && o2 == 8'd254)
            begin
                r.range_code = RNG_LINKLOCAL;
                need = 6'd16;
            end
            if (o1 == 8'd172 && o2[7:4] == 4'h1)
            begin
                r.range_code = RNG_PRIVATE172;
                need = 6'd12;
            end
        end
        else if (o1[7:5] == 3'b110)
        begin
            r.addr_class = CLS_C;
            r.classful_mask = MASK_CLASS_C;
            if (o1 == 8'd192 && o2 == 8'd168)
            begin
                r.range_code = RNG_PRIVATE192;
                need = 6'd16;
            end
            if (o1 == 8'd192 && o2 == 8'd88 && o3 == 8'd99)
            begin
                r.range_code = RNG_RELAY;
                need = 6'd24;
            end
            if (o1 == 8'd192 && o2 == 8'd0 && o3 == 8'd0)
            begin
                r.range_code = RNG_IANA;
                need = 6'd24;
            end
            if (o1 == 8'd192 && o2 == 8'd0 && o3 == 8'd2)
            begin
                r.range_code = RNG_TESTNET1;
                need = 6'd24;
            end
            // The benchmark block only matches with a zero third octet.
            if (o1 == 8'd198 && o2 == 8'd18 && o3 == 8'd0)
            begin
                r.range_code = RNG_BENCH;
                need = 6'd15;
            end
            if (o1 == 8'd198 && o2 == 8'd51 && o3 == 8'd100)
            begin
                r.range_code = RNG_TESTNET2;
                need = 6'd24;
            end
            if (o1 == 8'd203 && o2 == 8'd0 && o3 == 8'd113)
            begin
                r.range_code = RNG_TESTNET3;
                need = 6'd24;
            end
        end
        else if (o1[7:4] == 4'b1110)
        begin
            r.addr_class = CLS_D;
            r.range_code = RNG_MULTICAST;
        end
        else if (o1[7:3] == 5'b11110)
        begin
            r.addr_class = CLS_E;
            r.range_code = RNG_FUTURE;
        end
        else if (o1 == 8'hff)
        begin
            r.addr_class = CLS_BCAST;
            r.range_code = RNG_BCAST;
        end
        else
        begin
            r.addr_class = CLS_NONEXIST;
            r.range_code = RNG_NONEXIST;
        end
        r.classful_network = host & r.classful_mask;
        r.in_part = (need != 6'd0) && (r.mask_len < need);
        r.ptp_link = (r.mask_len == PREFIX_PTP) && (r.range_code != RNG_NONE)
                     && (r.range_code != RNG_NONEXIST);
        return r;
    endfunction

    // Most hosts land in or next to one of the special ranges.
    function automatic logic [31:0] pick_host();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 19))
            0: r[31:24] = 8'd0;
            1: r[31:24] = 8'd10;
            2: r[31:24] = 8'd127;
            3: r[31:16] = 16'ha9fe;
            4: r[31:20] = {8'd172, 4'h1};
            5: r[31:16] = 16'hc0a8;
            6: r[31:8] = 24'hc05863;
            7: r[31:8] = 24'hc00000;
            8: r[31:8] = 24'hc00002;
            9: r[31:8] = 24'hc61200;
            10: r[31:8] = 24'hc63364;
            11: r[31:8] = 24'hcb0071;
            12: r[31:24] = 8'hff;
            13: r[31:24] = 8'($urandom_range(248, 254));
            14: r[31:24] = 8'd172;
            15: r[31:16] = {8'd192, 8'($urandom_range(0, 2) * 84)};
            16: r[31:16] = {8'd198, 8'($urandom_range(17, 19))};
            17: r[31:8] = {8'd203, 8'd0, 8'($urandom_range(112, 114))};
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_mask();
        logic [31:0] r;
        int          len;
        len = ($urandom_range(0, 1) == 0) ? near_len[$urandom_range(0, 14)]
                                          : $urandom_range(0, 32);
        r = ~(MASK_ALL >> len);
        case ($urandom_range(0, 9))
            0: r = $urandom;
            1: r[$urandom_range(0, 31)] ^= 1'b1;
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_item(logic [31:0] host, logic [31:0] mask, subnet_info_t want);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= {mask, host};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        pending_info.push_back(want);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_info.size() != 0);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        subnet_info_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_info.size() == 0)
            begin
                $error("result transaction with nothing expected: 0x%0h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = pending_info.pop_front();
                check_field("bad_mask", 32'(want.bad_mask), 32'(m_axis_tdata[0]));
                check_field("mask_len", 32'(want.mask_len), 32'(m_axis_tdata[6:1]));
                check_field("network_addr", want.network_addr, m_axis_tdata[38:7]);
                check_field("broadcast_addr", want.broadcast_addr, m_axis_tdata[70:39]);
                check_field("classful_mask", want.classful_mask, m_axis_tdata[102:71]);
                check_field("classful_network", want.classful_network,
                            m_axis_tdata[134:103]);
                check_field("addr_class", 32'(want.addr_class), 32'(m_axis_tdata[137:135]));
                check_field("range_code", 32'(want.range_code), 32'(m_axis_tdata[142:138]));
                check_field("in_part", 32'(want.in_part), 32'(m_axis_tdata[143]));
                check_field("ptp_link", 32'(want.ptp_link), 32'(m_axis_tdata[144]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** ipv4_subnet_classifier: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result side: random stalls, plus one long hold-off once the run is well
    // under way so that the pipeline fills and stops taking input.
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 12);
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                stall = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial
    begin
        logic [31:0] host;
        logic [31:0] mask;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].host, dir_rows[i].mask,
                      dir_rows[i].typed ? dir_rows[i].want
                                        : compute_subnet_info(dir_rows[i].host,
                                                              dir_rows[i].mask));
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Alternate stretches of back-to-back traffic with random gaps.
            if (i % 150 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (i == PAUSE_AT)
                wait_drained();
            host = pick_host();
            mask = pick_mask();
            send_item(host, mask, compute_subnet_info(host, mask));
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("** ipv4_subnet_classifier: PASSED **");
        else
            $display("** ipv4_subnet_classifier: FAILED **");
        $finish;
    end

endmodule
